>>> design/tfp_pkg.sv
// Trigger frame parser package: beat types, result kind codes, field constants.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

    // Input beat: one frame body byte and its end-of-frame mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tfp_in_t;

    // Result beat.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  trigger_type;
        logic [11:0] length_or_aid;
        logic        more_or_ps160;
        logic        cs_required;
        logic [1:0]  ul_bandwidth;
        logic [1:0]  txs_mode;
        logic [5:0]  ap_tx_power;
        logic [15:0] spatial_reuse;
        logic        variant_he;
        logic [7:0]  ru_alloc;
        logic [8:0]  alloc_duration;
    } tfp_out_t;

    // Result handed from the parse core to the output buffer.
    typedef struct packed {
        logic     valid;
        tfp_out_t data;
    } tfp_res_beat_t;

    // Result kind codes.
    localparam logic [2:0] KIND_COMMON    = 3'd0;
    localparam logic [2:0] KIND_USER      = 3'd1;
    localparam logic [2:0] KIND_PADDING   = 3'd2;
    localparam logic [2:0] KIND_AID_PAD   = 3'd3;
    localparam logic [2:0] KIND_AID_RANGE = 3'd4;
    localparam logic [2:0] KIND_TRUNC     = 3'd5;

    localparam logic [11:0] AID_PAD_VALUE = 12'hfff;
    localparam logic [11:0] AID_MAX_VALID = 12'd2044;
    localparam logic [11:0] PAD_COUNT_MAX = 12'hfff;
    localparam logic [15:0] PAD_MARK      = 16'hffff;

endpackage : tfp_pkg

`default_nettype wire

>>> design/tfp_core.sv
// Parse core: byte collector, phase tracking and result decode.
// Depends on tfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfp_core
    import tfp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_parse_user,
    input  wire logic          beat_accept,
    input  wire tfp_in_t       beat,
    output tfp_res_beat_t      res
);

    typedef enum logic [1:0] {
        PH_COMMON = 2'd0,
        PH_USER   = 2'd1,
        PH_PAD    = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  idx_reg, idx_next;
    logic [11:0] pad_reg, pad_next;
    logic        he_reg, he_next;
    logic        parse_user_reg;

    logic [63:0] c;
    logic [11:0] aid;
    logic [11:0] pad_inc;

    always_comb
    begin
        // unwritten byte lanes are zero, so a plain insert matches an OR
        c = shift_reg;
        c[{idx_reg, 3'b000} +: 8] = beat.data_byte;
        aid = c[11:0];
        pad_inc = (pad_reg < PAD_COUNT_MAX) ? pad_reg + 12'd1 : pad_reg;

        phase_next = phase_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        he_next    = he_reg;
        res        = '0;

        unique case (phase_reg)
            PH_COMMON:
            begin
                if (idx_reg == 3'd7)
                begin
                    he_next                 = (c[55:54] == 2'b11);
                    res.valid               = 1'b1;
                    res.data.kind           = KIND_COMMON;
                    res.data.trigger_type   = c[3:0];
                    res.data.length_or_aid  = c[15:4];
                    res.data.more_or_ps160  = c[16];
                    res.data.cs_required    = c[17];
                    res.data.ul_bandwidth   = c[19:18];
                    res.data.txs_mode       = c[21:20];
                    res.data.ap_tx_power    = c[33:28];
                    res.data.spatial_reuse  = c[52:37];
                    res.data.variant_he     = he_next;
                    shift_next              = '0;
                    idx_next                = '0;
                    pad_next                = '0;
                    phase_next              = parse_user_reg ? PH_USER : PH_SKIP;
                end
                else
                begin
                    shift_next = c;
                    idx_next   = idx_reg + 3'd1;
                    if (beat.last_byte)
                    begin
                        res.valid     = 1'b1;
                        res.data.kind = KIND_TRUNC;
                    end
                end
            end
            PH_USER:
            begin
                case (idx_reg)
                    3'd0:
                    begin
                        shift_next = c;
                        idx_next   = 3'd1;
                    end
                    3'd1:
                    begin
                        if (c[15:0] == PAD_MARK)
                        begin
                            shift_next = '0;
                            idx_next   = '0;
                            pad_next   = 12'd2;
                            if (beat.last_byte)
                            begin
                                res.valid              = 1'b1;
                                res.data.kind          = KIND_PADDING;
                                res.data.length_or_aid = 12'd2;
                            end
                            else
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                        else
                        begin
                            shift_next = c;
                            idx_next   = 3'd2;
                            if (beat.last_byte)
                            begin
                                res.valid     = 1'b1;
                                res.data.kind = KIND_TRUNC;
                            end
                        end
                    end
                    3'd2:
                    begin
                        shift_next = c;
                        idx_next   = 3'd3;
                        if (beat.last_byte)
                        begin
                            res.valid     = 1'b1;
                            res.data.kind = KIND_TRUNC;
                        end
                    end
                    3'd3:
                    begin
                        if (aid == 12'd0 || aid > AID_MAX_VALID)
                        begin
                            res.valid              = 1'b1;
                            res.data.kind          = (aid == AID_PAD_VALUE) ?
                                                     KIND_AID_PAD : KIND_AID_RANGE;
                            res.data.length_or_aid = aid;
                            shift_next             = '0;
                            idx_next               = '0;
                            phase_next             = PH_SKIP;
                        end
                        else
                        begin
                            shift_next = c;
                            idx_next   = 3'd4;
                            if (beat.last_byte)
                            begin
                                res.valid     = 1'b1;
                                res.data.kind = KIND_TRUNC;
                            end
                        end
                    end
                    default:
                    begin
                        // fifth byte completes the user info field
                        res.valid               = 1'b1;
                        res.data.kind           = KIND_USER;
                        res.data.length_or_aid  = aid;
                        res.data.more_or_ps160  = he_reg ? 1'b0 : c[39];
                        res.data.variant_he     = he_reg;
                        res.data.ru_alloc       = c[19:12];
                        res.data.alloc_duration = c[28:20];
                        shift_next              = '0;
                        idx_next                = '0;
                    end
                endcase
            end
            PH_PAD:
            begin
                pad_next = pad_inc;
                if (beat.last_byte)
                begin
                    res.valid              = 1'b1;
                    res.data.kind          = KIND_PADDING;
                    res.data.length_or_aid = pad_inc;
                end
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase

        // frame end always returns to common info
        if (beat.last_byte)
        begin
            phase_next = PH_COMMON;
            shift_next = '0;
            idx_next   = '0;
            pad_next   = '0;
        end

        if (!beat_accept)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COMMON;
            shift_reg      <= '0;
            idx_reg        <= '0;
            pad_reg        <= '0;
            he_reg         <= 1'b1;
            parse_user_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                parse_user_reg <= cfg_parse_user;
            end
            if (beat_accept)
            begin
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                idx_reg   <= idx_next;
                pad_reg   <= pad_next;
                he_reg    <= he_next;
            end
        end
    end

endmodule : tfp_core

`default_nettype wire

>>> design/tfp_out_buf.sv
// Result output register with one skid entry.
// Depends on tfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfp_out_buf
    import tfp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tfp_res_beat_t push,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tfp_out_t           out_data
);

    logic     out_valid_reg;
    logic     skid_valid_reg;
    tfp_out_t out_data_reg;
    tfp_out_t skid_data_reg;
    logic     out_take;

    assign out_take  = out_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push.valid)
            begin
                if (out_valid_reg && !out_take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= push.data;
            end
            else
            begin
                out_data_reg <= push.data;
            end
        end
    end

endmodule : tfp_out_buf

`default_nettype wire

>>> design/trigger_frame_parser.sv
// Trigger frame parser top level: parse core plus output buffer.
// Depends on tfp_pkg, tfp_core, tfp_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                        Beat
// -------   ----------------------------   ----------------------------------
// in        in_valid, in_stall, in_data    one frame body byte + last mark
// out       out_valid, out_stall, out_data one parsed result (kind + fields)
// cfg       cfg_valid, cfg_ready, cfg_data parse_user_info register write
//
// One input beat per cycle while in_stall is low; each byte is decoded in the
// same cycle it is accepted, and its result, if any, is registered in the output
// register, or in the skid entry while the output is stalled. in_stall rises
// only when the skid entry behind a stalled output is full. cfg_ready is always
// high; writes are registered into parse_user_info. Reset (rst_n, async low)
// clears parser state, empties the output buffer, and sets parse_user_info to 1.

module trigger_frame_parser
    import tfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire tfp_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output tfp_out_t      out_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);

    logic          in_accept;
    logic          buf_full;
    tfp_res_beat_t core_res;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid & ~buf_full;

    // byte decode and frame state
    tfp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_parse_user (cfg_data),
        .beat_accept    (in_accept),
        .beat           (in_data),
        .res            (core_res)
    );

    // result register and skid entry
    tfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // skid entry only fills behind a held output beat
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("skid full while output register empty");

    // a result is produced only for an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n) core_res.valid |-> in_accept)
        else $error("result without accepted byte");

    // only user info results carry RU allocation or duration
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind != KIND_USER) |->
        (out_data.ru_alloc == 8'd0 && out_data.alloc_duration == 9'd0))
        else $error("user fields set on non-user result");

    // result kinds stay within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.kind <= KIND_TRUNC))
        else $error("undefined result kind");

endmodule : trigger_frame_parser

`default_nettype wire
